>>> src/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants of the bilinear resampler
// Field widths, register indexes, item layout and the fetch sequencer states.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int COORD_W    = 10;
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int SRC_W      = 7;
  localparam int DST_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int DEF_MAX_SRC_WIDTH  = 64;
  localparam int DEF_MAX_SRC_HEIGHT = 64;
  localparam int DEF_FRAC_BITS      = 8;

  // iterations of the coordinate divider per item
  localparam int DIV_CYCLES = 4;

  localparam logic [SRC_W-1:0] SRC_SIZE_RST = 7'd64;
  localparam logic [DST_W-1:0] DST_SIZE_RST = 11'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_RESAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [PIX_W-1:0]   pixel_rgb;
  } item_t;

  typedef struct packed {
    logic [SRC_W-1:0] src_width;
    logic [SRC_W-1:0] src_height;
    logic [DST_W-1:0] dst_width;
    logic [DST_W-1:0] dst_height;
  } cfg_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_RD1,
    FS_RD2,
    FS_RD3,
    FS_DONE
  } fetch_state_t;

endpackage

>>> src/brs_map.sv
// ----------------------------------------------------------------------------
// brs_map: destination to source coordinate mapping
// Multiplies by the source size, divides by the destination size in radix-2
// dividers, one for each axis, then removes the half pixel and clamps.
// ----------------------------------------------------------------------------
module brs_map #(
  parameter int MAX_SRC_WIDTH  = brs_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = brs_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int FRAC_BITS      = brs_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  brs_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  brs_pkg::item_t                    in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output brs_pkg::item_t                    out_item,
  output logic [$clog2(MAX_SRC_WIDTH)-1:0]  out_x0,
  output logic [$clog2(MAX_SRC_WIDTH)-1:0]  out_x1,
  output logic [$clog2(MAX_SRC_HEIGHT)-1:0] out_y0,
  output logic [$clog2(MAX_SRC_HEIGHT)-1:0] out_y1,
  output logic [FRAC_BITS-1:0]              out_tx,
  output logic [FRAC_BITS-1:0]              out_ty
);

  localparam int XW    = $clog2(MAX_SRC_WIDTH);
  localparam int YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int SW    = brs_pkg::SRC_W;
  localparam int DW    = brs_pkg::DST_W;
  localparam int PW    = brs_pkg::COORD_W + SW;
  localparam int NW    = PW + FRAC_BITS;
  localparam int QB    = SW + FRAC_BITS;
  localparam int NCYC  = brs_pkg::DIV_CYCLES;
  localparam int SPC   = (QB + NCYC - 1) / NCYC;
  localparam int DS    = SPC * NCYC;
  localparam int CNT_W = $clog2(NCYC);
  localparam int AXW   = 2 * SW + FRAC_BITS;

  // effective sizes, zero acts as one and source sizes clamp to the maximum
  logic [SW-1:0] sw_eff, sh_eff;
  logic [DW-1:0] dw_eff, dh_eff;

  always_comb begin
    priority if (cfg.src_width == '0) sw_eff = SW'(1);
    else if (int'(cfg.src_width) > MAX_SRC_WIDTH) sw_eff = SW'(MAX_SRC_WIDTH);
    else sw_eff = cfg.src_width;
    priority if (cfg.src_height == '0) sh_eff = SW'(1);
    else if (int'(cfg.src_height) > MAX_SRC_HEIGHT) sh_eff = SW'(MAX_SRC_HEIGHT);
    else sh_eff = cfg.src_height;
    dw_eff = (cfg.dst_width == '0) ? DW'(1) : cfg.dst_width;
    dh_eff = (cfg.dst_height == '0) ? DW'(1) : cfg.dst_height;
  end

  // ---------------- stage 0: scale by source size
  logic           s0_v_r;
  brs_pkg::item_t s0_item_r;
  logic [PW-1:0]  s0_px_r, s0_py_r;
  logic           s0_take;

  assign in_ready = !s0_v_r || s0_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_ready) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item_r <= in_item;
      s0_px_r   <= PW'(in_item.pos_x) * PW'(sw_eff);
      s0_py_r   <= PW'(in_item.pos_y) * PW'(sh_eff);
    end
  end

  // ---------------- divider: SPC quotient bits per cycle
  function automatic logic [DW+DS-1:0] div_step(logic [DW-1:0] r, logic [DS-1:0] n,
                                                logic [DW-1:0] d);
    logic [DW:0]   t;
    logic [DW-1:0] rr;
    logic [DS-1:0] nn;
    rr = r;
    nn = n;
    for (int i = 0; i < SPC; i++) begin
      t  = {rr, nn[DS-1]};
      nn = {nn[DS-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        nn[0] = 1'b1;
      end
      rr = t[DW-1:0];
    end
    return {rr, nn};
  endfunction

  logic             dv_busy_r;
  logic [CNT_W-1:0] dv_cnt_r;
  brs_pkg::item_t   dv_item_r;
  logic [DW-1:0]    rx_r, ry_r, rx_nxt, ry_nxt;
  logic [DS-1:0]    nx_r, ny_r, nx_nxt, ny_nxt;
  logic             ovx_r, ovy_r;
  logic             dv_last, q_free, q_load;
  logic [NW-1:0]    dx_full, dy_full;

  assign dv_last = dv_busy_r && (dv_cnt_r == CNT_W'(NCYC - 1));
  assign q_load  = dv_last && q_free;
  assign s0_take = s0_v_r && (!dv_busy_r || q_load);
  assign dx_full = {s0_px_r, {FRAC_BITS{1'b0}}};
  assign dy_full = {s0_py_r, {FRAC_BITS{1'b0}}};

  always_comb begin
    {rx_nxt, nx_nxt} = div_step(rx_r, nx_r, dw_eff);
    {ry_nxt, ny_nxt} = div_step(ry_r, ny_r, dh_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_cnt_r  <= '0;
    end else if (s0_take) begin
      dv_busy_r <= 1'b1;
      dv_cnt_r  <= '0;
    end else if (dv_busy_r && !dv_last) begin
      dv_cnt_r  <= dv_cnt_r + 1'b1;
    end else if (q_load) begin
      dv_busy_r <= 1'b0;
    end
  end

  // quotient overflow means the position lies past the last column or row
  always_ff @(posedge clk) begin
    if (s0_take) begin
      dv_item_r <= s0_item_r;
      rx_r      <= DW'(dx_full[NW-1:DS]);
      nx_r      <= dx_full[DS-1:0];
      ry_r      <= DW'(dy_full[NW-1:DS]);
      ny_r      <= dy_full[DS-1:0];
      ovx_r     <= {1'b0, s0_px_r[PW-1:SW]} >= dw_eff;
      ovy_r     <= {1'b0, s0_py_r[PW-1:SW]} >= dh_eff;
    end else if (dv_busy_r && !dv_last) begin
      rx_r <= rx_nxt;
      nx_r <= nx_nxt;
      ry_r <= ry_nxt;
      ny_r <= ny_nxt;
    end
  end

  // ---------------- quotient register
  logic           q_v_r;
  brs_pkg::item_t q_item_r;
  logic [DS-1:0]  qx_r, qy_r;
  logic           q_ovx_r, q_ovy_r;
  logic           post_take;

  assign q_free = !q_v_r || post_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (q_free) begin
      q_v_r <= q_load;
    end
  end

  always_ff @(posedge clk) begin
    if (q_load) begin
      q_item_r <= dv_item_r;
      qx_r     <= nx_nxt;
      qy_r     <= ny_nxt;
      q_ovx_r  <= ovx_r;
      q_ovy_r  <= ovy_r;
    end
  end

  // ---------------- half pixel offset, clamp and neighbor indexes
  function automatic logic [AXW-1:0] post_axis(logic [DS-1:0] q, logic ovf, logic [SW-1:0] s);
    logic [DS-1:0] half, qh;
    logic [QB-1:0] top, qc;
    logic [SW-1:0] i0, i1;
    half = DS'(1) << (FRAC_BITS - 1);
    top  = {s - 1'b1, {FRAC_BITS{1'b0}}};
    qh   = (q > half) ? q - half : '0;
    qc   = (ovf || (qh > DS'(top))) ? top : qh[QB-1:0];
    i0   = qc[QB-1:FRAC_BITS];
    i1   = ((i0 + 1'b1) < s) ? i0 + 1'b1 : s - 1'b1;
    return {i0, i1, qc[FRAC_BITS-1:0]};
  endfunction

  logic [AXW-1:0] pax, pay;

  always_comb begin
    pax = post_axis(qx_r, q_ovx_r, sw_eff);
    pay = post_axis(qy_r, q_ovy_r, sh_eff);
  end

  logic                 out_v_r;
  brs_pkg::item_t       out_item_r;
  logic [XW-1:0]        x0_r, x1_r;
  logic [YW-1:0]        y0_r, y1_r;
  logic [FRAC_BITS-1:0] tx_r, ty_r;

  assign post_take = q_v_r && (!out_v_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r <= q_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (post_take) begin
      out_item_r <= q_item_r;
      x0_r       <= XW'(pax[AXW-1:SW+FRAC_BITS]);
      x1_r       <= XW'(pax[SW+FRAC_BITS-1:FRAC_BITS]);
      tx_r       <= pax[FRAC_BITS-1:0];
      y0_r       <= YW'(pay[AXW-1:SW+FRAC_BITS]);
      y1_r       <= YW'(pay[SW+FRAC_BITS-1:FRAC_BITS]);
      ty_r       <= pay[FRAC_BITS-1:0];
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;
  assign out_x0    = x0_r;
  assign out_x1    = x1_r;
  assign out_y0    = y0_r;
  assign out_y1    = y1_r;
  assign out_tx    = tx_r;
  assign out_ty    = ty_r;

  // a running division counts up one step per cycle until its last step
  property p_div_advance;
    @(posedge clk) disable iff (!rst_n)
      (dv_busy_r && !dv_last && !s0_take) |=> (dv_busy_r && (dv_cnt_r == $past(dv_cnt_r) + 1'b1));
  endproperty
  a_div_advance: assert property (p_div_advance) else $error("divider step lost");

  // a finished quotient waits while the quotient register is full
  property p_div_hold;
    @(posedge clk) disable iff (!rst_n)
      (dv_last && !q_free) |=> (dv_last && $stable(nx_r) && $stable(ny_r));
  endproperty
  a_div_hold: assert property (p_div_hold) else $error("divider lost a stalled result");

endmodule

>>> src/brs_fetch.sv
// ----------------------------------------------------------------------------
// brs_fetch: frame store and neighbor fetch sequencer
// Writes loaded pixels and reads the four neighbors of a resample, one
// access per cycle on a single synchronous port, none while a result waits.
// ----------------------------------------------------------------------------
module brs_fetch #(
  parameter int MAX_SRC_WIDTH  = brs_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = brs_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int FRAC_BITS      = brs_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  brs_pkg::item_t                    in_item,
  input  logic [$clog2(MAX_SRC_WIDTH)-1:0]  in_x0,
  input  logic [$clog2(MAX_SRC_WIDTH)-1:0]  in_x1,
  input  logic [$clog2(MAX_SRC_HEIGHT)-1:0] in_y0,
  input  logic [$clog2(MAX_SRC_HEIGHT)-1:0] in_y1,
  input  logic [FRAC_BITS-1:0]              in_tx,
  input  logic [FRAC_BITS-1:0]              in_ty,
  output logic                              out_valid,
  input  logic                              out_ready,
  output brs_pkg::item_t                    out_item,
  output logic [brs_pkg::PIX_W-1:0]         out_c00,
  output logic [brs_pkg::PIX_W-1:0]         out_c10,
  output logic [brs_pkg::PIX_W-1:0]         out_c01,
  output logic [brs_pkg::PIX_W-1:0]         out_c11,
  output logic [FRAC_BITS-1:0]              out_tx,
  output logic [FRAC_BITS-1:0]              out_ty
);

  localparam int XW     = $clog2(MAX_SRC_WIDTH);
  localparam int YW     = $clog2(MAX_SRC_HEIGHT);
  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PW     = brs_pkg::PIX_W;

  brs_pkg::fetch_state_t state_r, state_nxt;

  brs_pkg::item_t       item_r;
  logic [XW-1:0]        x0_r, x1_r;
  logic [YW-1:0]        y0_r, y1_r;
  logic [FRAC_BITS-1:0] tx_r, ty_r;
  logic [PW-1:0]        c00_r, c10_r, c01_r;
  logic [PW-1:0]        q_r;
  logic [PW-1:0]        mem [DEPTH];

  logic                 acc, acc_rs, in_range, rd_phase;
  logic                 mem_we, mem_re;
  logic [XW-1:0]        ax;
  logic [YW-1:0]        ay;
  logic [ADDR_W-1:0]    mem_addr;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brs_pkg::FS_IDLE: if (acc_rs) state_nxt = brs_pkg::FS_RD1;
      brs_pkg::FS_RD1:  state_nxt = brs_pkg::FS_RD2;
      brs_pkg::FS_RD2:  state_nxt = brs_pkg::FS_RD3;
      brs_pkg::FS_RD3:  state_nxt = brs_pkg::FS_DONE;
      brs_pkg::FS_DONE: begin
        if (out_ready) state_nxt = acc_rs ? brs_pkg::FS_RD1 : brs_pkg::FS_IDLE;
      end
      default:          state_nxt = brs_pkg::FS_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rd_phase  = 1'b0;
    unique case (state_r)
      brs_pkg::FS_IDLE: in_ready = 1'b1;
      brs_pkg::FS_RD1,
      brs_pkg::FS_RD2,
      brs_pkg::FS_RD3:  rd_phase = 1'b1;
      brs_pkg::FS_DONE: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default:          in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brs_pkg::FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // access selection: first neighbor on the transfer cycle, then the rest
  assign acc      = in_valid && in_ready;
  assign acc_rs   = acc && (in_item.op == brs_pkg::OP_RESAMPLE);
  assign in_range = (int'(in_item.pos_x) < MAX_SRC_WIDTH) &&
                    (int'(in_item.pos_y) < MAX_SRC_HEIGHT);
  assign mem_we   = acc && (in_item.op == brs_pkg::OP_LOAD) && in_range;
  assign mem_re   = acc_rs || rd_phase;

  always_comb begin
    ax = x0_r;
    ay = y0_r;
    if (acc) begin
      ax = (in_item.op == brs_pkg::OP_LOAD) ? in_item.pos_x[XW-1:0] : in_x0;
      ay = (in_item.op == brs_pkg::OP_LOAD) ? in_item.pos_y[YW-1:0] : in_y0;
    end else begin
      unique case (state_r)
        brs_pkg::FS_RD1: begin ax = x1_r; ay = y0_r; end
        brs_pkg::FS_RD2: begin ax = x0_r; ay = y1_r; end
        brs_pkg::FS_RD3: begin ax = x1_r; ay = y1_r; end
        default:         begin ax = x0_r; ay = y0_r; end
      endcase
    end
  end

  assign mem_addr = ADDR_W'(int'(ay) * MAX_SRC_WIDTH + int'(ax));

  // frame store, one port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_item.pixel_rgb;
    end else if (mem_re) begin
      q_r <= mem[mem_addr];
    end
  end

  // item capture and neighbor collection
  always_ff @(posedge clk) begin
    if (acc) begin
      item_r <= in_item;
      x0_r   <= in_x0;
      x1_r   <= in_x1;
      y0_r   <= in_y0;
      y1_r   <= in_y1;
      tx_r   <= in_tx;
      ty_r   <= in_ty;
    end
    if (state_r == brs_pkg::FS_RD1) c00_r <= q_r;
    if (state_r == brs_pkg::FS_RD2) c10_r <= q_r;
    if (state_r == brs_pkg::FS_RD3) c01_r <= q_r;
  end

  assign out_item = item_r;
  assign out_c00  = c00_r;
  assign out_c10  = c10_r;
  assign out_c01  = c01_r;
  assign out_c11  = q_r;
  assign out_tx   = tx_r;
  assign out_ty   = ty_r;

  // the read sequence never stops halfway
  property p_rd_seq;
    @(posedge clk) disable iff (!rst_n)
      (state_r == brs_pkg::FS_RD3) |=> (state_r == brs_pkg::FS_DONE);
  endproperty
  a_rd_seq: assert property (p_rd_seq) else $error("neighbor read sequence broken");

  // last neighbor stays in the read register while the result waits
  property p_c11_hold;
    @(posedge clk) disable iff (!rst_n)
      (state_r == brs_pkg::FS_DONE && !out_ready) |=> $stable(q_r);
  endproperty
  a_c11_hold: assert property (p_c11_hold) else $error("read data changed during stall");

  // a store write never falls in the middle of a read sequence
  property p_no_wr_in_rd;
    @(posedge clk) disable iff (!rst_n)
      rd_phase |-> !mem_we;
  endproperty
  a_no_wr_in_rd: assert property (p_no_wr_in_rd) else $error("write during neighbor reads");

endmodule

>>> src/brs_blend.sv
// ----------------------------------------------------------------------------
// brs_blend: two-stage bilinear blend
// First stage blends horizontally, second stage vertically and truncates;
// the second stage is the result register.
// ----------------------------------------------------------------------------
module brs_blend #(
  parameter int FRAC_BITS = brs_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  brs_pkg::item_t                in_item,
  input  logic [brs_pkg::PIX_W-1:0]     in_c00,
  input  logic [brs_pkg::PIX_W-1:0]     in_c10,
  input  logic [brs_pkg::PIX_W-1:0]     in_c01,
  input  logic [brs_pkg::PIX_W-1:0]     in_c11,
  input  logic [FRAC_BITS-1:0]          in_tx,
  input  logic [FRAC_BITS-1:0]          in_ty,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [brs_pkg::COORD_W-1:0]   out_x,
  output logic [brs_pkg::COORD_W-1:0]   out_y,
  output logic [brs_pkg::PIX_W-1:0]     out_rgb
);

  localparam int CW = brs_pkg::CH_W;
  localparam int NC = brs_pkg::NUM_CH;
  localparam int WW = FRAC_BITS + 1;
  localparam int LW = CW + WW;
  localparam int VW = LW + WW;

  // ---------------- horizontal blend
  logic                 s1_v_r;
  logic [brs_pkg::COORD_W-1:0] s1_x_r, s1_y_r;
  logic [LW-1:0]        s1_top_r [NC];
  logic [LW-1:0]        s1_bot_r [NC];
  logic [FRAC_BITS-1:0] s1_ty_r;
  logic [WW-1:0]        wx0, wx1;
  logic [LW-1:0]        top_c [NC];
  logic [LW-1:0]        bot_c [NC];
  logic                 s2_take;

  assign in_ready = !s1_v_r || s2_take;
  assign wx1      = {1'b0, in_tx};
  assign wx0      = (WW'(1) << FRAC_BITS) - wx1;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      top_c[c] = LW'(in_c00[c*CW +: CW]) * LW'(wx0) + LW'(in_c10[c*CW +: CW]) * LW'(wx1);
      bot_c[c] = LW'(in_c01[c*CW +: CW]) * LW'(wx0) + LW'(in_c11[c*CW +: CW]) * LW'(wx1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x_r  <= in_item.pos_x;
      s1_y_r  <= in_item.pos_y;
      s1_ty_r <= in_ty;
      for (int c = 0; c < NC; c++) begin
        s1_top_r[c] <= top_c[c];
        s1_bot_r[c] <= bot_c[c];
      end
    end
  end

  // ---------------- vertical blend into the result register
  logic                        out_v_r;
  logic [brs_pkg::COORD_W-1:0] ox_r, oy_r;
  logic [brs_pkg::PIX_W-1:0]   orgb_r;
  logic [WW-1:0]               wy0, wy1;
  logic [VW-1:0]               vsum [NC];
  logic [brs_pkg::PIX_W-1:0]   rgb_c;

  assign s2_take = s1_v_r && (!out_v_r || out_ready);
  assign wy1     = {1'b0, s1_ty_r};
  assign wy0     = (WW'(1) << FRAC_BITS) - wy1;

  always_comb begin
    rgb_c = '0;
    for (int c = 0; c < NC; c++) begin
      vsum[c] = VW'(s1_top_r[c]) * VW'(wy0) + VW'(s1_bot_r[c]) * VW'(wy1);
      rgb_c[c*CW +: CW] = vsum[c][2*FRAC_BITS +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      ox_r   <= s1_x_r;
      oy_r   <= s1_y_r;
      orgb_r <= rgb_c;
    end
  end

  assign out_valid = out_v_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_rgb   = orgb_r;

endmodule

>>> src/bilinear_image_resampler_top.sv
// ----------------------------------------------------------------------------
// bilinear_image_resampler_top: bilinear RGB image resampler
// Frame store of source pixels, and bilinear resampling of destination pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer. in_op load writes in_pixel_rgb to the source
//           pixel (in_pos_x, in_pos_y); out-of-range loads are dropped and give
//           no result. in_op resample names a destination pixel and gives
//           exactly one result on out_*.
//   out_* : destination coordinates and the blended pixel.
//   cfg_* : register index and data; always ready. Write only while idle.
// Overlap: the coordinate divider needs four iterations per item, and the
//   single-port frame store needs four reads per resample; both units run
//   overlapped with the other stages, and each takes its next item only as it
//   finishes the last.
// Reset: sizes return to 64 by 64 on both sides; the frame store keeps its
//   contents and must be loaded before it is read.
// Stalls: the result register holds while out_ready is low; stages behind it
//   fill up and then in_ready drops.
// ----------------------------------------------------------------------------
module bilinear_image_resampler_top #(
  parameter int MAX_SRC_WIDTH  = brs_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = brs_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int FRAC_BITS      = brs_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [brs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [brs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [brs_pkg::COORD_W-1:0]      in_pos_x,
  input  logic [brs_pkg::COORD_W-1:0]      in_pos_y,
  input  logic [brs_pkg::PIX_W-1:0]        in_pixel_rgb,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [brs_pkg::COORD_W-1:0]      out_x,
  output logic [brs_pkg::COORD_W-1:0]      out_y,
  output logic [brs_pkg::PIX_W-1:0]        out_rgb
);

  localparam int XW = $clog2(MAX_SRC_WIDTH);
  localparam int YW = $clog2(MAX_SRC_HEIGHT);

  // configuration registers
  brs_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= brs_pkg::SRC_SIZE_RST;
      cfg_r.src_height <= brs_pkg::SRC_SIZE_RST;
      cfg_r.dst_width  <= brs_pkg::DST_SIZE_RST;
      cfg_r.dst_height <= brs_pkg::DST_SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        brs_pkg::REG_SRC_WIDTH:  cfg_r.src_width  <= cfg_data[brs_pkg::SRC_W-1:0];
        brs_pkg::REG_SRC_HEIGHT: cfg_r.src_height <= cfg_data[brs_pkg::SRC_W-1:0];
        brs_pkg::REG_DST_WIDTH:  cfg_r.dst_width  <= cfg_data[brs_pkg::DST_W-1:0];
        brs_pkg::REG_DST_HEIGHT: cfg_r.dst_height <= cfg_data[brs_pkg::DST_W-1:0];
        default: ;
      endcase
    end
  end

  // input item
  brs_pkg::item_t in_item;

  always_comb begin
    in_item.op        = brs_pkg::op_t'(in_op);
    in_item.pos_x     = in_pos_x;
    in_item.pos_y     = in_pos_y;
    in_item.pixel_rgb = in_pixel_rgb;
  end

  // mapping to fetch
  logic                 m_valid, m_ready;
  brs_pkg::item_t       m_item;
  logic [XW-1:0]        m_x0, m_x1;
  logic [YW-1:0]        m_y0, m_y1;
  logic [FRAC_BITS-1:0] m_tx, m_ty;

  brs_map #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .FRAC_BITS      (FRAC_BITS)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_item  (m_item),
    .out_x0    (m_x0),
    .out_x1    (m_x1),
    .out_y0    (m_y0),
    .out_y1    (m_y1),
    .out_tx    (m_tx),
    .out_ty    (m_ty)
  );

  // fetch to blend
  logic                      f_valid, f_ready;
  brs_pkg::item_t            f_item;
  logic [brs_pkg::PIX_W-1:0] f_c00, f_c10, f_c01, f_c11;
  logic [FRAC_BITS-1:0]      f_tx, f_ty;

  brs_fetch #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .FRAC_BITS      (FRAC_BITS)
  ) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .in_item   (m_item),
    .in_x0     (m_x0),
    .in_x1     (m_x1),
    .in_y0     (m_y0),
    .in_y1     (m_y1),
    .in_tx     (m_tx),
    .in_ty     (m_ty),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item),
    .out_c00   (f_c00),
    .out_c10   (f_c10),
    .out_c01   (f_c01),
    .out_c11   (f_c11),
    .out_tx    (f_tx),
    .out_ty    (f_ty)
  );

  brs_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .in_c00    (f_c00),
    .in_c10    (f_c10),
    .in_c01    (f_c01),
    .in_c11    (f_c11),
    .in_tx     (f_tx),
    .in_ty     (f_ty),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_rgb   (out_rgb)
  );

endmodule

>>> test/bilinear_image_resampler_top_tb.sv
// ----------------------------------------------------------------------------
// bilinear_image_resampler_top_tb: self-checking bench of the bilinear resampler
// Loads source pixels, resamples destination pixels under several size
// settings and idle patterns, and compares each result with a local predictor.
// ----------------------------------------------------------------------------
module bilinear_image_resampler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW       = brs_pkg::DEF_MAX_SRC_WIDTH;
  localparam int MAXH       = brs_pkg::DEF_MAX_SRC_HEIGHT;
  localparam int FRAC       = brs_pkg::DEF_FRAC_BITS;
  localparam int DEPTH      = MAXW * MAXH;
  localparam int DRAIN_CYC  = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int NUM_PHASES = 11;
  localparam int RAND_PER_PHASE = 140;

  typedef struct {
    logic [brs_pkg::COORD_W-1:0] x;
    logic [brs_pkg::COORD_W-1:0] y;
    logic [brs_pkg::PIX_W-1:0]   rgb;
  } pix_result_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [brs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [brs_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, in_op;
  logic [brs_pkg::COORD_W-1:0] in_pos_x, in_pos_y;
  logic [brs_pkg::PIX_W-1:0] in_pixel_rgb;
  logic out_valid, out_ready;
  logic [brs_pkg::COORD_W-1:0] out_x, out_y;
  logic [brs_pkg::PIX_W-1:0] out_rgb;

  bilinear_image_resampler_top u_dut (.*);

  // predictor state
  logic [brs_pkg::PIX_W-1:0] pix_store [DEPTH];
  bit               pix_written [DEPTH];
  int unsigned      sz_src_w, sz_src_h, sz_dst_w, sz_dst_h;

  brs_pkg::item_t item_queue [$];
  pix_result_t pix_expected [$];
  int          send_idle, recv_stall;
  int          mismatches;
  int unsigned cycles;
  int unsigned n_queued;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned eff_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // fixed-point source position of a destination coordinate, clamped
  function automatic longint unsigned src_pos(int unsigned d, int unsigned sw,
                                              int unsigned dw);
    longint unsigned q, top;
    q = ((longint'(d) * sw) << FRAC) / dw;
    top = longint'(sw - 1) << FRAC;
    q = (q > (1 << (FRAC - 1))) ? q - (1 << (FRAC - 1)) : 0;
    return (q > top) ? top : q;
  endfunction

  // four neighbor addresses plus the weights of one resample
  task automatic neighbors(input int unsigned px, input int unsigned py,
                           output int unsigned addr[4], output longint unsigned tx,
                           output longint unsigned ty);
    int unsigned sw, sh, x0, y0, x1, y1;
    longint unsigned gx, gy;
    sw = eff_size(sz_src_w, MAXW);
    sh = eff_size(sz_src_h, MAXH);
    gx = src_pos(px, sw, eff_size(sz_dst_w, 2048));
    gy = src_pos(py, sh, eff_size(sz_dst_h, 2048));
    x0 = 32'(gx >> FRAC);
    y0 = 32'(gy >> FRAC);
    tx = gx & ((1 << FRAC) - 1);
    ty = gy & ((1 << FRAC) - 1);
    x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
    y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
    addr[0] = y0 * MAXW + x0;
    addr[1] = y0 * MAXW + x1;
    addr[2] = y1 * MAXW + x0;
    addr[3] = y1 * MAXW + x1;
  endtask

  // apply one accepted item to the predictor
  task automatic predict_item(input brs_pkg::item_t it);
    int unsigned addr[4];
    longint unsigned tx, ty, a, b, c, d, v, one;
    pix_result_t r;
    if (it.op == brs_pkg::OP_LOAD) begin
      if (it.pos_x < MAXW && it.pos_y < MAXH)
        pix_store[it.pos_y * MAXW + it.pos_x] = it.pixel_rgb;
    end else begin
      neighbors(it.pos_x, it.pos_y, addr, tx, ty);
      one = 1 << FRAC;
      r.x = it.pos_x;
      r.y = it.pos_y;
      r.rgb = '0;
      for (int ch = 0; ch < brs_pkg::NUM_CH; ch++) begin
        a = pix_store[addr[0]][ch*brs_pkg::CH_W +: brs_pkg::CH_W];
        b = pix_store[addr[1]][ch*brs_pkg::CH_W +: brs_pkg::CH_W];
        c = pix_store[addr[2]][ch*brs_pkg::CH_W +: brs_pkg::CH_W];
        d = pix_store[addr[3]][ch*brs_pkg::CH_W +: brs_pkg::CH_W];
        v = ((a * (one - tx) + b * tx) * (one - ty) + (c * (one - tx) + d * tx) * ty)
            >> (2 * FRAC);
        r.rgb[ch*brs_pkg::CH_W +: brs_pkg::CH_W] = v[brs_pkg::CH_W-1:0];
      end
      pix_expected.push_back(r);
    end
  endtask

  function automatic logic [brs_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return brs_pkg::PIX_W'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  task automatic queue_load(input int unsigned px, input int unsigned py,
                            input logic [brs_pkg::PIX_W-1:0] rgb);
    brs_pkg::item_t it;
    it.op = brs_pkg::OP_LOAD;
    it.pos_x = brs_pkg::COORD_W'(px);
    it.pos_y = brs_pkg::COORD_W'(py);
    it.pixel_rgb = rgb;
    item_queue.push_back(it);
    n_queued++;
    if (px < MAXW && py < MAXH) pix_written[py * MAXW + px] = 1'b1;
  endtask

  // resample, loading any unwritten neighbor first
  task automatic queue_resample(input int unsigned px, input int unsigned py);
    int unsigned addr[4];
    longint unsigned tx, ty;
    brs_pkg::item_t it;
    neighbors(px, py, addr, tx, ty);
    foreach (addr[k])
      if (!pix_written[addr[k]]) queue_load(addr[k] % MAXW, addr[k] / MAXW, rand_pixel());
    it.op = brs_pkg::OP_RESAMPLE;
    it.pos_x = brs_pkg::COORD_W'(px);
    it.pos_y = brs_pkg::COORD_W'(py);
    it.pixel_rgb = brs_pkg::PIX_W'($urandom_range(0, 24'hFFFFFF));
    item_queue.push_back(it);
    n_queued++;
  endtask

  task automatic write_reg(input logic [brs_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= brs_pkg::CFG_DATA_W'(data);
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      brs_pkg::REG_SRC_WIDTH:  sz_src_w = data & 'h7F;
      brs_pkg::REG_SRC_HEIGHT: sz_src_h = data & 'h7F;
      brs_pkg::REG_DST_WIDTH:  sz_dst_w = data & 'h7FF;
      brs_pkg::REG_DST_HEIGHT: sz_dst_h = data & 'h7FF;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (item_queue.size() != 0 || in_valid || pix_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    logic holding;
    holding = in_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(item_queue.pop_front());
        holding = 1'b0;
      end
      if (!holding) begin
        if (item_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          in_valid     <= 1'b1;
          in_op        <= item_queue[0].op;
          in_pos_x     <= item_queue[0].pos_x;
          in_pos_y     <= item_queue[0].pos_y;
          in_pixel_rgb <= item_queue[0].pixel_rgb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pix_result_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pix_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result x=%0d y=%0d rgb=%06h", out_x, out_y, out_rgb);
        end else begin
          e = pix_expected.pop_front();
          if (out_x !== e.x || out_y !== e.y || out_rgb !== e.rgb) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%0d y=%0d rgb=%06h, got x=%0d y=%0d rgb=%06h",
                       e.x, e.y, e.rgb, out_x, out_y, out_rgb);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bilinear_image_resampler_top regression: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned sizes [NUM_PHASES][4];
    int unsigned px, py, dw, dh, goal;
    sizes = '{
      '{64, 64, 64, 64}, '{1, 1, 1, 1}, '{64, 64, 1024, 1024}, '{0, 0, 0, 0},
      '{127, 127, 2047, 2047}, '{1, 64, 1024, 3}, '{64, 1, 7, 1024},
      '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_op = brs_pkg::OP_LOAD;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pixel_rgb = '0;
    out_ready = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    mismatches = 0;
    cycles = 0;
    n_queued = 0;
    sz_src_w = brs_pkg::SRC_SIZE_RST;
    sz_src_h = brs_pkg::SRC_SIZE_RST;
    sz_dst_w = brs_pkg::DST_SIZE_RST;
    sz_dst_h = brs_pkg::DST_SIZE_RST;
    foreach (pix_written[k]) pix_written[k] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corners, extremes and loads outside the store
    queue_load(0, 0, 24'hFFFFFF);
    queue_load(MAXW - 1, MAXH - 1, 24'h000000);
    queue_load(1, 0, 24'h000000);
    queue_load(0, 1, 24'h00FF00);
    queue_load(1, 1, 24'hFF00FF);
    queue_load(1023, 1023, 24'h123456);
    queue_load(MAXW, 0, 24'hABCDEF);
    queue_load(0, MAXH, 24'hABCDEF);
    queue_resample(0, 0);
    queue_resample(1, 1);
    queue_resample(63, 63);
    queue_resample(1023, 1023);
    queue_resample(1023, 0);
    queue_resample(0, 1023);
    queue_resample(32, 17);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (ph > 0) begin
        if (ph >= 7) begin
          sizes[ph][0] = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(0, 2047);
          sizes[ph][1] = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(0, 2047);
          sizes[ph][2] = $urandom_range(1, 1024);
          sizes[ph][3] = $urandom_range(1, 2047);
        end
        write_reg(brs_pkg::REG_SRC_WIDTH,  sizes[ph][0]);
        write_reg(brs_pkg::REG_SRC_HEIGHT, sizes[ph][1]);
        write_reg(brs_pkg::REG_DST_WIDTH,  sizes[ph][2]);
        write_reg(brs_pkg::REG_DST_HEIGHT, sizes[ph][3]);
        // unknown index must change nothing
        write_reg(brs_pkg::CFG_IDX_W'($urandom_range(4, 7)), $urandom_range(0, 2047));
      end
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 77; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 77; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      dw = eff_size(sz_dst_w, 1024);
      dh = eff_size(sz_dst_h, 1024);
      // fixed item budget per phase, neighbor loads included
      goal = n_queued + RAND_PER_PHASE;
      while (n_queued < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            if ($urandom_range(0, 9) == 0) queue_load($urandom_range(0, 1023),
                                                      $urandom_range(0, 1023), rand_pixel());
            else queue_load($urandom_range(0, MAXW - 1), $urandom_range(0, MAXH - 1),
                            rand_pixel());
          end
          3: queue_resample($urandom_range(0, 1023), $urandom_range(0, 1023));
          default: begin
            px = $urandom_range(0, dw - 1);
            py = $urandom_range(0, dh - 1);
            queue_resample(px, py);
          end
        endcase
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("bilinear_image_resampler_top regression: pass");
    else
      $display("bilinear_image_resampler_top regression: fail");
    $finish;
  end

endmodule
